FILE: design/clte_pkg.sv
// ----------------------------------------------------------------------------
// clte_pkg: shared types for the convolution layer training engine
// Action codes, controller/datapath command and status structs, default
// geometry and saturation helpers.
// ----------------------------------------------------------------------------
package clte_pkg;

  // default geometry
  localparam int DEF_IN_CHANNELS  = 4;
  localparam int DEF_IN_SIZE      = 16;
  localparam int DEF_KERNEL_SIZE  = 3;
  localparam int DEF_OUT_CHANNELS = 8;

  // learning rate after reset, unsigned Q0.16
  localparam logic [15:0] LR_RESET = 16'd655;

  // item actions
  typedef enum logic [2:0] {
    ACT_LOAD_IN  = 3'd0,
    ACT_LOAD_W   = 3'd1,
    ACT_FWD      = 3'd2,
    ACT_GRAD     = 3'd3,
    ACT_READ     = 3'd4,
    ACT_CLR_GRAD = 3'd5,
    ACT_UPDATE   = 3'd6,
    ACT_CLR_ACC  = 3'd7
  } act_t;

  // controller to datapath
  typedef struct packed {
    logic latch;       // capture the accepted item
    logic issue;       // one tap or sweep step at the current count
    logic init;        // step belongs to the post-reset clearing pass
    logic load_write;  // write a loaded element or weight
    logic emit;        // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    act_t act;
    logic range_ok;
    logic busy;
    logic has_result;
    logic out_stall;
  } status_t;

  // saturate a 33-bit sum to 32 bits; bit 32 of the result flags saturation
  function automatic logic [32:0] sat32(input logic signed [32:0] v);
    logic [32:0] r;
    if (v > 33'sh0_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -33'sh0_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // saturate a 22-bit difference to 16 bits; bit 16 flags saturation
  function automatic logic [16:0] sat16w(input logic signed [21:0] v);
    logic [16:0] r;
    if (v > 22'sd32767) begin
      r = {1'b1, 16'h7FFF};
    end else if (v < -22'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

endpackage

FILE: design/clte_ram.sv
// ----------------------------------------------------------------------------
// clte_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/clte_ctrl.sv
// ----------------------------------------------------------------------------
// clte_ctrl: sequencer of the convolution layer training engine
// Accepts items, steps tap and sweep counts and decides when a result leaves.
// ----------------------------------------------------------------------------
module clte_ctrl #(
  parameter int IN_CHANNELS  = 4,
  parameter int IN_SIZE      = 16,
  parameter int KERNEL_SIZE  = 3,
  parameter int OUT_CHANNELS = 8,
  parameter int COUNT_W      = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output clte_pkg::cmd_t       cmd,
  input  clte_pkg::status_t    status,
  output logic [COUNT_W-1:0]   count
);
  import clte_pkg::*;

  localparam int TAPS      = IN_CHANNELS * KERNEL_SIZE * KERNEL_SIZE;
  localparam int IN_DEPTH  = IN_CHANNELS * IN_SIZE * IN_SIZE;
  localparam int W_DEPTH   = OUT_CHANNELS * TAPS;
  localparam int MAX_DEPTH = (IN_DEPTH > W_DEPTH) ? IN_DEPTH : W_DEPTH;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DECODE, S_RUN, S_DRAIN, S_FINISH
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] last;

  // command decode
  always_comb begin
    in_ready       = (state == S_IDLE);
    cmd.latch      = (state == S_IDLE) && in_valid;
    cmd.issue      = (state == S_RUN) || (state == S_INIT);
    cmd.init       = (state == S_INIT);
    cmd.load_write = (state == S_DECODE) && status.range_ok &&
                     ((status.act == ACT_LOAD_IN) || (status.act == ACT_LOAD_W));
    cmd.emit       = (state == S_FINISH) && status.has_result && !status.out_stall;
  end

  // state, count and sweep length
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      count <= '0;
      last  <= COUNT_W'(MAX_DEPTH - 1);
    end else begin
      case (state)
        S_INIT: begin
          count <= count + 1'b1;
          if (count == last) begin
            count <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          count <= '0;
          case (status.act)
            ACT_LOAD_IN, ACT_LOAD_W: begin
              state <= status.range_ok ? S_IDLE : S_FINISH;
            end
            ACT_FWD, ACT_GRAD: begin
              last  <= COUNT_W'(TAPS - 1);
              state <= status.range_ok ? S_RUN : S_FINISH;
            end
            ACT_READ: begin
              last  <= '0;
              state <= status.range_ok ? S_RUN : S_FINISH;
            end
            ACT_CLR_GRAD: begin
              last  <= COUNT_W'(IN_DEPTH - 1);
              state <= S_RUN;
            end
            ACT_UPDATE, ACT_CLR_ACC: begin
              last  <= COUNT_W'(W_DEPTH - 1);
              state <= S_RUN;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_RUN: begin
          count <= count + 1'b1;
          if (count == last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!status.busy) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!status.has_result || !status.out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/clte_datapath.sv
// ----------------------------------------------------------------------------
// clte_datapath: stores and arithmetic of the convolution layer training engine
// Item register, address generation, four RAMs, a two-stage
// multiply/accumulate pipeline and the output register.
// ----------------------------------------------------------------------------
module clte_datapath #(
  parameter int IN_CHANNELS  = 4,
  parameter int IN_SIZE      = 16,
  parameter int KERNEL_SIZE  = 3,
  parameter int OUT_CHANNELS = 8,
  parameter int COUNT_W      = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        s_axis_tdata,
  input  logic [2:0]         s_axis_tuser,
  input  clte_pkg::cmd_t     cmd,
  input  logic [COUNT_W-1:0] count,
  output clte_pkg::status_t  status,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_data,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,
  output logic [0:0]         m_axis_tuser
);
  import clte_pkg::*;

  localparam int TAPS     = IN_CHANNELS * KERNEL_SIZE * KERNEL_SIZE;
  localparam int IN_DEPTH = IN_CHANNELS * IN_SIZE * IN_SIZE;
  localparam int W_DEPTH  = OUT_CHANNELS * TAPS;
  localparam int OUT_SIZE = IN_SIZE - KERNEL_SIZE + 1;
  localparam int IN_AW    = $clog2(IN_DEPTH);
  localparam int W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int CHW      = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int KW       = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
  localparam int SUMW     = 33 + ((TAPS > 1) ? $clog2(TAPS) : 0);
  localparam logic signed [SUMW-1:0] Y_MAX = SUMW'(32767);
  localparam logic signed [SUMW-1:0] Y_MIN = SUMW'(-32768);
  localparam logic signed [SUMW-1:0] Y_HALF = SUMW'(2048);
  localparam logic signed [48:0] STEP_HALF = 49'sd134217728;

  // item register
  act_t               act;
  logic [2:0]         f_q;
  logic [1:0]         ch_q;
  logic [3:0]         r_q, c_q;
  logic signed [15:0] d_q;
  logic [15:0]        lr;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act  <= act_t'(s_axis_tuser);
      f_q  <= s_axis_tdata[2:0];
      ch_q <= s_axis_tdata[4:3];
      r_q  <= s_axis_tdata[8:5];
      c_q  <= s_axis_tdata[12:9];
      d_q  <= $signed(s_axis_tdata[28:13]);
    end
  end

  // learning rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      lr <= LR_RESET;
    end else if (cfg_valid) begin
      lr <= cfg_data;
    end
  end

  // index range checks
  logic in_ok, w_ok, p_ok, range_ok;
  always_comb begin
    in_ok = (int'(ch_q) < IN_CHANNELS) && (int'(r_q) < IN_SIZE) && (int'(c_q) < IN_SIZE);
    w_ok  = (int'(f_q) < OUT_CHANNELS) && (int'(ch_q) < IN_CHANNELS) &&
            (int'(r_q) < KERNEL_SIZE) && (int'(c_q) < KERNEL_SIZE);
    p_ok  = (int'(f_q) < OUT_CHANNELS) && (int'(r_q) < OUT_SIZE) && (int'(c_q) < OUT_SIZE);
    case (act)
      ACT_LOAD_IN, ACT_READ: range_ok = in_ok;
      ACT_LOAD_W:            range_ok = w_ok;
      ACT_FWD, ACT_GRAD:     range_ok = p_ok;
      default:               range_ok = 1'b1;
    endcase
  end

  // tap position within the window: channel, row, column
  logic [CHW-1:0] tk;
  logic [KW-1:0]  ti, tj;
  logic           tap_issue, pipe_issue;

  assign tap_issue  = cmd.issue && !cmd.init && ((act == ACT_FWD) || (act == ACT_GRAD));
  assign pipe_issue = cmd.issue && !cmd.init &&
                      ((act == ACT_FWD) || (act == ACT_GRAD) ||
                       (act == ACT_READ) || (act == ACT_UPDATE));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tk <= '0;
      ti <= '0;
      tj <= '0;
    end else if (tap_issue) begin
      if (tj == KW'(KERNEL_SIZE - 1)) begin
        tj <= '0;
        if (ti == KW'(KERNEL_SIZE - 1)) begin
          ti <= '0;
          tk <= tk + 1'b1;
        end else begin
          ti <= ti + 1'b1;
        end
      end else begin
        tj <= tj + 1'b1;
      end
    end
  end

  // addresses
  logic [IN_AW-1:0] tap_xi, pt_xi, rd_g, xi1, xi2;
  logic [W_AW-1:0]  tap_wi, pt_wi, rd_w, wi1, wi2;

  always_comb begin
    tap_xi = IN_AW'((int'(tk) * IN_SIZE + int'(r_q) + int'(ti)) * IN_SIZE +
                    int'(c_q) + int'(tj));
    tap_wi = W_AW'(((int'(f_q) * IN_CHANNELS + int'(tk)) * KERNEL_SIZE + int'(ti)) *
                   KERNEL_SIZE + int'(tj));
    pt_xi  = IN_AW'((int'(ch_q) * IN_SIZE + int'(r_q)) * IN_SIZE + int'(c_q));
    pt_wi  = W_AW'(((int'(f_q) * IN_CHANNELS + int'(ch_q)) * KERNEL_SIZE + int'(r_q)) *
                   KERNEL_SIZE + int'(c_q));
    rd_g   = (act == ACT_READ) ? pt_xi : tap_xi;
    rd_w   = (act == ACT_UPDATE) ? count[W_AW-1:0] : tap_wi;
  end

  // stores
  logic        x_we, w_we, a_we, g_we;
  logic [IN_AW-1:0] x_wa, g_wa;
  logic [W_AW-1:0]  w_wa, a_wa;
  logic [15:0] x_wd, w_wd, x_rd, w_rd;
  logic [31:0] a_wd, g_wd, a_rd, g_rd;

  clte_ram #(.WIDTH(16), .DEPTH(IN_DEPTH), .AW(IN_AW)) u_input_ram (
    .clk(clk), .we(x_we), .waddr(x_wa), .wdata(x_wd), .raddr(tap_xi), .rdata(x_rd)
  );
  clte_ram #(.WIDTH(16), .DEPTH(W_DEPTH), .AW(W_AW)) u_weight_ram (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(rd_w), .rdata(w_rd)
  );
  clte_ram #(.WIDTH(32), .DEPTH(W_DEPTH), .AW(W_AW)) u_acc_ram (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(rd_w), .rdata(a_rd)
  );
  clte_ram #(.WIDTH(32), .DEPTH(IN_DEPTH), .AW(IN_AW)) u_grad_ram (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(rd_g), .rdata(g_rd)
  );

  // pipeline stage 1: read data in, products out
  logic                v1, v2;
  logic signed [31:0]  mul_xw, mul_dw, mul_dx;
  logic signed [48:0]  mul_al;
  logic signed [48:0]  p1;
  logic signed [31:0]  p2, g2, acc2;
  logic signed [15:0]  w2;

  assign mul_xw = $signed(x_rd) * $signed(w_rd);
  assign mul_dw = d_q * $signed(w_rd);
  assign mul_dx = d_q * $signed(x_rd);
  assign mul_al = $signed(a_rd) * $signed({1'b0, lr});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= pipe_issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    xi1 <= tap_xi;
    wi1 <= rd_w;
    xi2 <= xi1;
    wi2 <= wi1;
    if (v1) begin
      case (act)
        ACT_FWD:    p1 <= 49'(mul_xw);
        ACT_UPDATE: p1 <= mul_al;
        default:    p1 <= 49'(mul_dw);
      endcase
      p2   <= mul_dx;
      g2   <= $signed(g_rd);
      acc2 <= $signed(a_rd);
      w2   <= $signed(w_rd);
    end
  end

  // pipeline stage 2: saturating updates
  logic [32:0]        g_sat, a_sat;
  logic [16:0]        w_sat;
  logic signed [48:0] step_full;
  logic signed [20:0] step;
  logic signed [21:0] w_diff;

  always_comb begin
    g_sat     = sat32({g2[31], g2} + {p1[31], p1[31:0]});
    a_sat     = sat32({acc2[31], acc2} + {p2[31], p2});
    step_full = (p1 + STEP_HALF) >>> 28;
    step      = step_full[20:0];
    w_diff    = {{6{w2[15]}}, w2} - {step[20], step};
    w_sat     = sat16w(w_diff);
  end

  // forward sum and error flag of the item
  logic signed [SUMW-1:0] sum_q, y_full;
  logic                   err_q, y_err;
  logic [15:0]            y_sat;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sum_q <= '0;
      err_q <= 1'b0;
    end else if (v2) begin
      case (act)
        ACT_FWD:    sum_q <= sum_q + SUMW'($signed(p1[31:0]));
        ACT_GRAD:   err_q <= err_q | g_sat[32] | a_sat[32];
        ACT_UPDATE: err_q <= err_q | w_sat[16];
        default:    err_q <= err_q;
      endcase
    end
  end

  // round forward sum to Q4.12, ties up, then saturate
  always_comb begin
    y_full = (sum_q + Y_HALF) >>> 12;
    if (y_full > Y_MAX) begin
      y_sat = 16'h7FFF;
      y_err = 1'b1;
    end else if (y_full < Y_MIN) begin
      y_sat = 16'h8000;
      y_err = 1'b1;
    end else begin
      y_sat = y_full[15:0];
      y_err = 1'b0;
    end
  end

  // store write ports
  always_comb begin
    x_we = cmd.load_write && (act == ACT_LOAD_IN);
    x_wa = pt_xi;
    x_wd = d_q;

    w_we = 1'b0;
    w_wa = pt_wi;
    w_wd = d_q;
    if (cmd.load_write && (act == ACT_LOAD_W)) begin
      w_we = 1'b1;
    end else if (v2 && (act == ACT_UPDATE)) begin
      w_we = 1'b1;
      w_wa = wi2;
      w_wd = w_sat[15:0];
    end

    a_we = 1'b0;
    a_wa = wi2;
    a_wd = '0;
    if (v2 && (act == ACT_GRAD)) begin
      a_we = 1'b1;
      a_wd = a_sat[31:0];
    end else if (v2 && (act == ACT_UPDATE)) begin
      a_we = 1'b1;
    end else if (cmd.issue && (cmd.init || (act == ACT_CLR_ACC)) &&
                 (int'(count) < W_DEPTH)) begin
      a_we = 1'b1;
      a_wa = count[W_AW-1:0];
    end

    g_we = 1'b0;
    g_wa = xi2;
    g_wd = '0;
    if (v2 && (act == ACT_GRAD)) begin
      g_we = 1'b1;
      g_wd = g_sat[31:0];
    end else if (cmd.issue && (cmd.init || (act == ACT_CLR_GRAD)) &&
                 (int'(count) < IN_DEPTH)) begin
      g_we = 1'b1;
      g_wa = count[IN_AW-1:0];
    end
  end

  // result selection
  logic        has_result, res_err;
  logic [31:0] res_val;

  always_comb begin
    res_val = '0;
    res_err = 1'b1;
    if (!range_ok) begin
      has_result = 1'b1;
    end else begin
      case (act)
        ACT_FWD: begin
          has_result = 1'b1;
          res_val    = {{16{y_sat[15]}}, y_sat};
          res_err    = y_err;
        end
        ACT_READ: begin
          has_result = 1'b1;
          res_val    = g2;
          res_err    = 1'b0;
        end
        ACT_GRAD, ACT_UPDATE: has_result = err_q;
        default:              has_result = 1'b0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= res_val;
      m_axis_tuser <= res_err;
    end
  end

  // status back to the controller
  always_comb begin
    status.act        = act;
    status.range_ok   = range_ok;
    status.busy       = v1 | v2;
    status.has_result = has_result;
    status.out_stall  = m_axis_tvalid && !m_axis_tready;
  end

endmodule

FILE: design/conv_layer_train_engine.sv
// ----------------------------------------------------------------------------
// conv_layer_train_engine: convolution layer with training
// Valid, stride-1 multi-channel convolution with forward, backward and
// weight update over on-chip stores.
// ----------------------------------------------------------------------------
// One item is processed at a time; a result waits in the output register
// while the next item is taken, and an item with a result of its own holds
// until that register is free. A forward or gradient point reads one tap per
// cycle from each store and multiplies it through a two-stage pipeline; a
// gradient read fetches a single element, an update sweeps every weight
// address, an accumulator clear every weight address and a gradient clear
// every input address. After reset a clearing pass over max(input depth,
// weight depth) addresses (1024 by default) zeroes the accumulators and input
// gradients; no item is accepted during it.
module conv_layer_train_engine #(
  parameter int IN_CHANNELS  = clte_pkg::DEF_IN_CHANNELS,
  parameter int IN_SIZE      = clte_pkg::DEF_IN_SIZE,
  parameter int KERNEL_SIZE  = clte_pkg::DEF_KERNEL_SIZE,
  parameter int OUT_CHANNELS = clte_pkg::DEF_OUT_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  // filter[2:0], channel[4:3], row[8:5], col[12:9], data[28:13], zero[31:29]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  // result_value[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // error[0], set on a range error or on saturation
  output logic [0:0]  m_axis_tuser,
  // learning rate, unsigned Q0.16
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import clte_pkg::*;

  localparam int TAPS      = IN_CHANNELS * KERNEL_SIZE * KERNEL_SIZE;
  localparam int IN_DEPTH  = IN_CHANNELS * IN_SIZE * IN_SIZE;
  localparam int W_DEPTH   = OUT_CHANNELS * TAPS;
  localparam int MAX_DEPTH = (IN_DEPTH > W_DEPTH) ? IN_DEPTH : W_DEPTH;
  localparam int COUNT_W   = $clog2(MAX_DEPTH);

  cmd_t               cmd;
  status_t            status;
  logic [COUNT_W-1:0] count;

  assign cfg_ready = 1'b1;

  clte_ctrl #(
    .IN_CHANNELS(IN_CHANNELS), .IN_SIZE(IN_SIZE), .KERNEL_SIZE(KERNEL_SIZE),
    .OUT_CHANNELS(OUT_CHANNELS), .COUNT_W(COUNT_W)
  ) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(cmd), .status(status), .count(count)
  );

  clte_datapath #(
    .IN_CHANNELS(IN_CHANNELS), .IN_SIZE(IN_SIZE), .KERNEL_SIZE(KERNEL_SIZE),
    .OUT_CHANNELS(OUT_CHANNELS), .COUNT_W(COUNT_W)
  ) u_datapath (
    .clk(clk), .rst(rst), .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .cmd(cmd), .count(count), .status(status),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // a new item is never taken while the pipeline still holds taps
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !status.busy)
    else $error("item accepted with pipeline busy");

  // sweep steps and item capture never overlap
  a_issue_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !s_axis_tready && !cmd.latch)
    else $error("issue while accepting");

  // a result only appears after an emit command
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.emit))
    else $error("output valid without emit");

endmodule
